[hdl/assert_macros.svh]
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CSP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hdl/csp_pkg.sv]
package csp_pkg;

    localparam int unsigned DirW   = 32;
    localparam int unsigned CfgW   = 31;
    localparam int unsigned NumW   = 62;   // radius * |component|
    localparam int unsigned HalfW  = 31;
    localparam int unsigned SumW   = 64;   // x*x + y*y
    localparam int unsigned SqW    = 63;
    localparam int unsigned RemW   = 124;  // numerator squared
    localparam int unsigned AccW   = 94;   // q * s
    localparam int unsigned QW     = 31;
    localparam int unsigned RootStages = 31;
    // ratio pipe depth: two prep stages plus one per result bit
    localparam int unsigned RatioLat = RootStages + 2;

    localparam logic CfgRadius = 1'b0;
    localparam logic CfgLength = 1'b1;

    localparam logic [CfgW-1:0] RadiusReset = 31'd65536;
    localparam logic [CfgW-1:0] LengthReset = 31'd131072;

    typedef struct packed {
        logic ce;
    } t_pipe_ctl;

    typedef struct packed {
        logic            neg_x;
        logic            neg_y;
        logic            lat_zero;
        logic [DirW-1:0] pz;
    } t_side;

    function automatic logic [DirW-1:0] mag32(input logic [DirW-1:0] v);
        mag32 = v[DirW-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

[hdl/csp_ratio_pipe.sv]
// floor(n / sqrt(s)) by bit-serial restoring search, one result bit per stage.
// Keeps rem = n^2 - q^2*s and acc = q*s so no stage needs a multiplier.
module csp_ratio_pipe (
    input  logic                           i_clk,
    input  csp_pkg::t_pipe_ctl             i_ctl,
    input  logic [csp_pkg::NumW-1:0]       i_n,
    input  logic [csp_pkg::SumW-1:0]       i_s,
    output logic [csp_pkg::QW-1:0]         o_q
);

    localparam int unsigned HW = csp_pkg::NumW / 2;

    logic [2*HW-1:0]            r_hh;
    logic [2*HW-1:0]            r_hl;
    logic [2*HW-1:0]            r_ll;
    logic [csp_pkg::SumW-1:0]   r_sa;

    logic [csp_pkg::RemW-1:0]   r_e [0:csp_pkg::RootStages];
    logic [csp_pkg::AccW-1:0]   r_a [0:csp_pkg::RootStages];
    logic [csp_pkg::QW-1:0]     r_q [0:csp_pkg::RootStages];
    logic [csp_pkg::SumW-1:0]   r_s [0:csp_pkg::RootStages];

    logic [csp_pkg::RemW-1:0]   n_e0;

    // numerator squared from three half-width partial products
    always_comb begin
        n_e0 = {r_hh, {(2*HW){1'b0}}}
             + ({{(csp_pkg::RemW-2*HW){1'b0}}, r_hl} << (HW + 1))
             + {{(csp_pkg::RemW-2*HW){1'b0}}, r_ll};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ce) begin
            r_hh <= i_n[csp_pkg::NumW-1:HW] * i_n[csp_pkg::NumW-1:HW];
            r_hl <= i_n[csp_pkg::NumW-1:HW] * i_n[HW-1:0];
            r_ll <= i_n[HW-1:0] * i_n[HW-1:0];
            r_sa <= i_s;
            r_e[0] <= n_e0;
            r_a[0] <= '0;
            r_q[0] <= '0;
            r_s[0] <= r_sa;
        end
    end

    for (genvar g = 0; g < csp_pkg::RootStages; g++) begin : g_bit
        localparam int unsigned B = csp_pkg::RootStages - 1 - g;
        logic [127:0]               w_inc;
        logic                       w_take;

        assign w_inc = ({{(128-csp_pkg::AccW){1'b0}}, r_a[g]} << (B + 1))
                     + ({{(128-csp_pkg::SumW){1'b0}}, r_s[g]} << (2 * B));
        assign w_take = w_inc <= {{(128-csp_pkg::RemW){1'b0}}, r_e[g]};

        always_ff @(posedge i_clk) begin
            if (i_ctl.ce) begin
                r_s[g+1] <= r_s[g];
                if (w_take) begin
                    r_e[g+1] <= r_e[g] - w_inc[csp_pkg::RemW-1:0];
                    r_a[g+1] <= r_a[g] + ({{(csp_pkg::AccW-csp_pkg::SumW){1'b0}}, r_s[g]} << B);
                    r_q[g+1] <= r_q[g] | (csp_pkg::QW'(1) << B);
                end else begin
                    r_e[g+1] <= r_e[g];
                    r_a[g+1] <= r_a[g];
                    r_q[g+1] <= r_q[g];
                end
            end
        end
    end

    assign o_q = r_q[csp_pkg::RootStages];

endmodule

[hdl/cylinder_support_point_top.sv]
// channel   valid         ready         payload
// request   i_in_valid    o_in_ready    i_dir_x, i_dir_y, i_dir_z
// result    o_out_valid   i_out_ready   o_pt_x, o_pt_y, o_pt_z
// config    i_cfg_valid   o_cfg_ready   i_cfg_index, i_cfg_data
//
// One request per cycle while the output is not stalled. One product stage, the
// ratio pipe of 33 stages (two for squaring, one per result bit), then the output.
// The whole pipeline advances while the output register is empty or taken.
// Reset (synchronous, active low) clears valid bits and sets the registers
// to radius 1.0 and length 2.0. Config writes are always taken.
module cylinder_support_point_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [31:0]         i_dir_x,
    input  logic signed [31:0]         i_dir_y,
    input  logic signed [31:0]         i_dir_z,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [31:0]         o_pt_x,
    output logic signed [31:0]         o_pt_y,
    output logic signed [31:0]         o_pt_z,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [31:0]                i_cfg_data
);

    `include "assert_macros.svh"

    localparam int unsigned DW = csp_pkg::DirW;

    logic [csp_pkg::CfgW-1:0]   r_radius;
    logic [csp_pkg::CfgW-1:0]   r_length;

    csp_pkg::t_pipe_ctl         w_ctl;
    logic [DW-1:0]              w_mx, w_my, w_mz;
    logic [csp_pkg::HalfW-1:0]  w_half;
    csp_pkg::t_side             n_side;

    logic                       r_v1;
    csp_pkg::t_side             r_side1;
    logic [csp_pkg::NumW-1:0]   r_nx, r_ny;
    logic [csp_pkg::SqW-1:0]    r_sqx, r_sqy;
    logic [csp_pkg::SumW-1:0]   w_s;

    logic                       r_v   [1:csp_pkg::RatioLat];
    csp_pkg::t_side             r_side[1:csp_pkg::RatioLat];

    logic [csp_pkg::QW-1:0]     w_qx, w_qy;
    logic                       r_out_valid;
    logic [DW-1:0]              r_px, r_py, r_pz;
    csp_pkg::t_side             w_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= csp_pkg::RadiusReset;
            r_length <= csp_pkg::LengthReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                csp_pkg::CfgRadius: r_radius <= i_cfg_data[csp_pkg::CfgW-1:0];
                csp_pkg::CfgLength: r_length <= i_cfg_data[csp_pkg::CfgW-1:0];
                default: ;
            endcase
        end
    end

    assign w_ctl.ce   = !r_out_valid || i_out_ready;
    assign o_in_ready = w_ctl.ce;

    assign w_mx   = csp_pkg::mag32(i_dir_x);
    assign w_my   = csp_pkg::mag32(i_dir_y);
    assign w_mz   = csp_pkg::mag32(i_dir_z);
    assign w_half = {1'b0, r_length[csp_pkg::CfgW-1:1]};

    always_comb begin
        n_side.neg_x    = i_dir_x[DW-1];
        n_side.neg_y    = i_dir_y[DW-1];
        n_side.lat_zero = (w_mx == '0) && (w_my == '0);
        if (w_mz == '0) begin
            n_side.pz = '0;
        end else if (i_dir_z[DW-1]) begin
            n_side.pz = ~{1'b0, w_half} + 1'b1;
        end else begin
            n_side.pz = {1'b0, w_half};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_ctl.ce) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.ce) begin
            r_side1 <= n_side;
            r_nx    <= r_radius * w_mx;
            r_ny    <= r_radius * w_my;
            r_sqx   <= csp_pkg::SqW'(w_mx * w_mx);
            r_sqy   <= csp_pkg::SqW'(w_my * w_my);
        end
    end

    assign w_s = {1'b0, r_sqx} + {1'b0, r_sqy};

    csp_ratio_pipe u_ratio_x (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_n   (r_nx),
        .i_s   (w_s),
        .o_q   (w_qx)
    );

    csp_ratio_pipe u_ratio_y (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_n   (r_ny),
        .i_s   (w_s),
        .o_q   (w_qy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= csp_pkg::RatioLat; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (w_ctl.ce) begin
            r_v[1] <= r_v1;
            for (int k = 2; k <= csp_pkg::RatioLat; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.ce) begin
            r_side[1] <= r_side1;
            for (int k = 2; k <= csp_pkg::RatioLat; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign w_last = r_side[csp_pkg::RatioLat];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.ce) begin
            r_out_valid <= r_v[csp_pkg::RatioLat];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.ce) begin
            r_pz <= w_last.pz;
            if (w_last.lat_zero) begin
                r_px <= '0;
                r_py <= '0;
            end else begin
                r_px <= w_last.neg_x ? ~{1'b0, w_qx} + 1'b1 : {1'b0, w_qx};
                r_py <= w_last.neg_y ? ~{1'b0, w_qy} + 1'b1 : {1'b0, w_qy};
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pt_x      = r_px;
    assign o_pt_y      = r_py;
    assign o_pt_z      = r_pz;

    `CSP_ASSERT_ALWAYS(a_reset_empty, $past(!i_rst_n) |-> !o_out_valid, "valid after reset")
    `CSP_ASSERT(a_hold, (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_px) && $stable(r_pz)), "stalled result changed")
    `CSP_ASSERT(a_z_bound, o_out_valid |-> ((o_pt_z[31:30] == 2'b00) || (o_pt_z[31:30] == 2'b11)), "pt_z beyond half length range")

endmodule
